FILE: rtl/rdrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotational disk request queue package
// Widths, codes, entry layout, control words and distance helpers.
// ----------------------------------------------------------------------------
package rdrq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int SECTOR_BITS = 12;

  localparam int ADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OP_W       = 2;
  localparam int ID_W       = 8;
  localparam int TGT_W      = 12;
  localparam int SC_W       = 13;
  localparam int TPS_W      = 20;
  localparam int TIME_W     = 32;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam int DIST_W = ((SECTOR_BITS > SC_W) ? SECTOR_BITS : SC_W) + 2;
  localparam int PROD_W = ((TPS_W + DIST_W - 1) > (TIME_W + 1)) ?
                          (TPS_W + DIST_W - 1) : (TIME_W + 1);

  localparam logic [SC_W-1:0]  SC_RESET  = SC_W'(64);
  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_SECTOR = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  typedef struct packed {
    logic [ID_W-1:0]        pid;
    logic [ID_W-1:0]        rid;
    logic [SECTOR_BITS-1:0] sector;
    logic                   fresh;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic latch;
    logic err_full;
    logic err_empty;
    logic rd_prev;
    logic wr_shift;
    logic wr_new;
    logic pop;
    logic q_calc;
    logic q_mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            idx_zero;
    logic            shift_go;
    logic            out_free;
  } sts_t;

  function automatic logic signed [DIST_W-1:0] fwd_dist(
    input logic [SECTOR_BITS-1:0] sec,
    input logic [SECTOR_BITS-1:0] head,
    input logic [SC_W-1:0]        sc,
    input logic                   allow_zero
  );
    logic signed [DIST_W-1:0] d;
    d = $signed(DIST_W'(sec)) - $signed(DIST_W'(head));
    if (allow_zero ? (d < 0) : (d <= 0)) begin
      d = d + $signed(DIST_W'(sc));
    end
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_add(
    input logic [ADDR_W-1:0] base,
    input logic [CNT_W-1:0]  off
  );
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/rdrq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotational disk request queue channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface rdrq_in_if;
  logic                                valid;
  logic                                ready;
  logic [rdrq_pkg::OP_W-1:0]           operation;
  logic [rdrq_pkg::ID_W-1:0]           process_id;
  logic [rdrq_pkg::ID_W-1:0]           request_id;
  logic [rdrq_pkg::TGT_W-1:0]          target_sector;
  logic                                fresh_write;

  modport source (output valid, operation, process_id, request_id, target_sector,
                  fresh_write, input ready);
  modport sink (input valid, operation, process_id, request_id, target_sector,
                fresh_write, output ready);
endinterface

interface rdrq_out_if;
  logic                         valid;
  logic                         ready;
  logic [rdrq_pkg::TIME_W-1:0]  time_until_ready;
  logic                         queue_empty;
  logic [rdrq_pkg::ID_W-1:0]    head_process_id;
  logic [rdrq_pkg::ID_W-1:0]    head_request_id;
  logic [rdrq_pkg::ERR_W-1:0]   error;

  modport source (output valid, time_until_ready, queue_empty, head_process_id,
                  head_request_id, error, input ready);
  modport sink (input valid, time_until_ready, queue_empty, head_process_id,
                head_request_id, error, output ready);
endinterface

interface rdrq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rdrq_pkg::CFG_IDX_W-1:0]    index;
  logic [rdrq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/rdrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rdrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rdrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotational disk request queue controller
// Sequences insert scans, pops, queries and result delivery.
// ----------------------------------------------------------------------------
module rdrq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rdrq_pkg::sts_t sts_i,
  output rdrq_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_CHK,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_RD,
    S_REM_POP,
    S_QRY_RD,
    S_QRY_CALC,
    S_QRY_MUL,
    S_FIN_RD,
    S_FIN_OUT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          rdrq_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.err_full = 1'b1;
              state_d        = S_FIN_RD;
            end else begin
              state_d = S_INS_CHK;
            end
          end
          rdrq_pkg::OP_REMOVE: begin
            if (sts_i.empty) begin
              cmd_o.err_empty = 1'b1;
              state_d         = S_FIN_RD;
            end else begin
              state_d = S_REM_RD;
            end
          end
          rdrq_pkg::OP_QUERY: begin
            state_d = sts_i.empty ? S_FIN_RD : S_QRY_RD;
          end
          default: begin
            state_d = S_FIN_RD;
          end
        endcase
      end
      S_INS_CHK: begin
        if (sts_i.idx_zero) begin
          state_d = S_INS_PUT;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.shift_go) begin
          cmd_o.wr_shift = 1'b1;
          state_d        = S_INS_CHK;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_new = 1'b1;
        state_d      = S_FIN_RD;
      end
      S_REM_RD: begin
        state_d = S_REM_POP;
      end
      S_REM_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_FIN_RD;
      end
      S_QRY_RD: begin
        state_d = S_QRY_CALC;
      end
      S_QRY_CALC: begin
        cmd_o.q_calc = 1'b1;
        state_d      = S_QRY_MUL;
      end
      S_QRY_MUL: begin
        cmd_o.q_mul = 1'b1;
        state_d     = S_FIN_RD;
      end
      S_FIN_RD: begin
        state_d = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rdrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotational disk request queue datapath
// Circular request store, distance compare, query multiply, result register.
// ----------------------------------------------------------------------------
module rdrq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rdrq_pkg::cmd_t                      cmd_i,
  output rdrq_pkg::sts_t                      sts_o,
  input  logic [rdrq_pkg::OP_W-1:0]           operation_i,
  input  logic [rdrq_pkg::ID_W-1:0]           process_id_i,
  input  logic [rdrq_pkg::ID_W-1:0]           request_id_i,
  input  logic [rdrq_pkg::TGT_W-1:0]          target_sector_i,
  input  logic                                fresh_write_i,
  input  logic                                cfg_valid_i,
  input  logic [rdrq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rdrq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [rdrq_pkg::TIME_W-1:0]         time_until_ready_o,
  output logic                                queue_empty_o,
  output logic [rdrq_pkg::ID_W-1:0]           head_process_id_o,
  output logic [rdrq_pkg::ID_W-1:0]           head_request_id_o,
  output logic [rdrq_pkg::ERR_W-1:0]          error_o
);

  logic [rdrq_pkg::CNT_W-1:0]       count_q, count_d;
  logic [rdrq_pkg::CNT_W-1:0]       idx_q, idx_d;
  logic [rdrq_pkg::ADDR_W-1:0]      head_ptr_q, head_ptr_d;
  logic [rdrq_pkg::SECTOR_BITS-1:0] head_sec_q, head_sec_d;
  logic [rdrq_pkg::SC_W-1:0]        sc_q;
  logic [rdrq_pkg::TPS_W-1:0]       tps_q;
  logic                             out_valid_q;

  rdrq_pkg::entry_t                 new_q;
  logic [rdrq_pkg::OP_W-1:0]        op_q;
  logic [rdrq_pkg::ERR_W-1:0]       err_q;
  logic [rdrq_pkg::DIST_W-2:0]      dist_q, dist_d;
  logic [rdrq_pkg::TIME_W-1:0]      time_q, time_d;
  logic [rdrq_pkg::TIME_W-1:0]      out_time_q;
  logic                             out_empty_q;
  logic [rdrq_pkg::ID_W-1:0]        out_pid_q, out_rid_q;
  logic [rdrq_pkg::ERR_W-1:0]       out_err_q;

  rdrq_pkg::entry_t                 rd_e, wr_e;
  logic [rdrq_pkg::ENTRY_W-1:0]     rd_data;
  logic [rdrq_pkg::ADDR_W-1:0]      rd_addr, wr_addr, tail_addr;
  logic                             wr_en;
  logic signed [rdrq_pkg::DIST_W-1:0] d_new, d_old, qd, qd_adj;
  logic                             q_zero_fresh;
  logic [rdrq_pkg::PROD_W-1:0]      prod;

  assign rd_e = rd_data;

  assign tail_addr = rdrq_pkg::wrap_add(head_ptr_q, idx_q);
  assign rd_addr   = cmd_i.rd_prev ?
                     rdrq_pkg::wrap_add(head_ptr_q, idx_q - rdrq_pkg::CNT_W'(1)) :
                     head_ptr_q;

  assign d_new = rdrq_pkg::fwd_dist(new_q.sector, head_sec_q, sc_q, 1'b0);
  assign d_old = rdrq_pkg::fwd_dist(rd_e.sector, head_sec_q, sc_q, 1'b0);
  assign qd    = rdrq_pkg::fwd_dist(rd_e.sector, head_sec_q, sc_q, 1'b1);

  assign q_zero_fresh = (qd == '0) && rd_e.fresh;

  always_comb begin
    if (q_zero_fresh) begin
      qd_adj = $signed(rdrq_pkg::DIST_W'(sc_q));
    end else if (qd < 0) begin
      qd_adj = '0;
    end else begin
      qd_adj = qd;
    end
    dist_d = qd_adj[rdrq_pkg::DIST_W-2:0];
  end

  assign prod   = rdrq_pkg::PROD_W'(tps_q) * rdrq_pkg::PROD_W'(dist_q);
  assign time_d = (|prod[rdrq_pkg::PROD_W-1:rdrq_pkg::TIME_W]) ? '1 :
                  prod[rdrq_pkg::TIME_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_addr;
    wr_e    = new_q;
    if (cmd_i.wr_shift) begin
      wr_en = 1'b1;
      wr_e  = rd_e;
    end else if (cmd_i.wr_new) begin
      wr_en = 1'b1;
    end else if (cmd_i.q_calc && q_zero_fresh) begin
      wr_en      = 1'b1;
      wr_addr    = head_ptr_q;
      wr_e       = rd_e;
      wr_e.fresh = 1'b0;
    end
  end

  rdrq_ram #(
    .WIDTH (rdrq_pkg::ENTRY_W),
    .DEPTH (rdrq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_e),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    head_ptr_d = head_ptr_q;
    head_sec_d = head_sec_q;
    if (cmd_i.latch) begin
      idx_d = count_q;
    end
    if (cmd_i.wr_shift) begin
      idx_d = idx_q - rdrq_pkg::CNT_W'(1);
    end
    if (cmd_i.wr_new) begin
      count_d = count_q + rdrq_pkg::CNT_W'(1);
    end
    if (cmd_i.pop) begin
      head_sec_d = rd_e.sector;
      head_ptr_d = rdrq_pkg::wrap_add(head_ptr_q, rdrq_pkg::CNT_W'(1));
      count_d    = count_q - rdrq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      head_ptr_q  <= '0;
      head_sec_q  <= '0;
      sc_q        <= rdrq_pkg::SC_RESET;
      tps_q       <= rdrq_pkg::TPS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      idx_q      <= idx_d;
      head_ptr_q <= head_ptr_d;
      head_sec_q <= head_sec_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rdrq_pkg::CFG_SECTOR_COUNT:    sc_q  <= cfg_data_i[rdrq_pkg::SC_W-1:0];
          rdrq_pkg::CFG_TIME_PER_SECTOR: tps_q <= cfg_data_i[rdrq_pkg::TPS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q         <= operation_i;
      new_q.pid    <= process_id_i;
      new_q.rid    <= request_id_i;
      new_q.sector <= rdrq_pkg::SECTOR_BITS'(target_sector_i);
      new_q.fresh  <= fresh_write_i;
      err_q        <= rdrq_pkg::ERR_NONE;
      time_q       <= '0;
    end
    if (cmd_i.err_full) begin
      err_q <= rdrq_pkg::ERR_FULL;
    end
    if (cmd_i.err_empty) begin
      err_q <= rdrq_pkg::ERR_EMPTY;
    end
    if (cmd_i.q_calc) begin
      dist_q <= dist_d;
    end
    if (cmd_i.q_mul) begin
      time_q <= time_d;
    end
    if (cmd_i.load_out) begin
      out_time_q  <= time_q;
      out_empty_q <= (count_q == '0);
      out_pid_q   <= (count_q == '0) ? '0 : rd_e.pid;
      out_rid_q   <= (count_q == '0) ? '0 : rd_e.rid;
      out_err_q   <= err_q;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.full     = (count_q >= rdrq_pkg::CNT_W'(rdrq_pkg::QUEUE_DEPTH));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.shift_go = (d_new < d_old);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign time_until_ready_o = out_time_q;
  assign queue_empty_o      = out_empty_q;
  assign head_process_id_o  = out_pid_q;
  assign head_request_id_o  = out_rid_q;
  assign error_o            = out_err_q;

endmodule

FILE: rtl/rotational_disk_request_queue.sv
`timescale 1ns / 1ps
// Each word runs DISP, its op states, then FIN_RD and FIN_OUT: remove REM_RD, REM_POP;
// query QRY_RD, QRY_CALC, QRY_MUL; insert its scan and INS_PUT; rejected or empty-queue: none.
// Throughput: one word in flight; the next word is taken the cycle after the result registers.
// Insert scan: INS_CHK reads an entry (registered port), INS_CMP writes it one slot tailward.
// Reset: queue empty, head sector 0, sector_count 64, time_per_sector 1; no clearing pass.
// ----------------------------------------------------------------------------
// Rotational disk request queue
// Requests sorted by forward rotational distance, with insert, remove, query.
// ----------------------------------------------------------------------------
module rotational_disk_request_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdrq_in_if.sink     in_i,
  rdrq_out_if.source  out_o,
  rdrq_cfg_if.sink    cfg_i
);

  rdrq_pkg::cmd_t cmd;
  rdrq_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  rdrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdrq_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .operation_i        (in_i.operation),
    .process_id_i       (in_i.process_id),
    .request_id_i       (in_i.request_id),
    .target_sector_i    (in_i.target_sector),
    .fresh_write_i      (in_i.fresh_write),
    .cfg_valid_i        (cfg_i.valid),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .time_until_ready_o (out_o.time_until_ready),
    .queue_empty_o      (out_o.queue_empty),
    .head_process_id_o  (out_o.head_process_id),
    .head_request_id_o  (out_o.head_request_id),
    .error_o            (out_o.error)
  );

endmodule

FILE: rtl/rdrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotational disk request queue checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module rdrq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rdrq_pkg::TIME_W-1:0]   time_i,
  input logic                          empty_i,
  input logic [rdrq_pkg::ID_W-1:0]     pid_i,
  input logic [rdrq_pkg::ID_W-1:0]     rid_i,
  input logic [rdrq_pkg::ERR_W-1:0]    err_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(time_i) && $stable(empty_i)
      && $stable(pid_i) && $stable(rid_i) && $stable(err_i))
    else $error("result word changed while stalled");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (err_i == rdrq_pkg::ERR_FULL) |-> !empty_i)
    else $error("full error reported with empty queue");

  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (err_i == rdrq_pkg::ERR_EMPTY) |-> empty_i)
    else $error("empty error reported with pending requests");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_i |-> (pid_i == '0) && (rid_i == '0) && (time_i == '0))
    else $error("empty queue reports nonzero head or time");

  a_err_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (err_i != rdrq_pkg::ERR_NONE) |-> (time_i == '0))
    else $error("rejected word reports a time");

endmodule

bind rotational_disk_request_queue rdrq_checker u_rdrq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .time_i      (out_o.time_until_ready),
  .empty_i     (out_o.queue_empty),
  .pid_i       (out_o.head_process_id),
  .rid_i       (out_o.head_request_id),
  .err_i       (out_o.error)
);
